// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bmp24_pkg.sv =====
`default_nettype none

package bmp24_pkg;

  // Error codes carried in the result's error field.
  localparam logic [3:0] ERR_NONE   = 4'd0;
  localparam logic [3:0] ERR_SIG    = 4'd1;
  localparam logic [3:0] ERR_INFO   = 4'd2;
  localparam logic [3:0] ERR_PLANES = 4'd3;
  localparam logic [3:0] ERR_DEPTH  = 4'd4;
  localparam logic [3:0] ERR_COMP   = 4'd5;
  localparam logic [3:0] ERR_DIMS   = 4'd6;
  localparam logic [3:0] ERR_CTAB   = 4'd7;
  localparam logic [3:0] ERR_OFFSET = 4'd8;
  localparam logic [3:0] ERR_BIG    = 4'd9;
  localparam logic [3:0] ERR_TRUNC  = 4'd10;

  // File header plus info header is 54 bytes.
  localparam logic [5:0]  HDR_LAST  = 6'd53;
  localparam logic [31:0] HDR_BYTES = 32'd54;

  typedef struct packed {
    logic [3:0] code;      // lowest-numbered header fault bit set so far
    logic       top_down;  // negative height in the header
    logic       start54;   // pixel data follows the header directly
  } hdr_stat_t;

endpackage

`default_nettype wire

// ===== src/bmp24_stream_decoder_top.sv =====
// Path: the byte that causes a result is held in the input register, and the result
// in the result register (one input register, one result register).
// Throughput: one byte per cycle; the input register advances whenever the result
// register is empty or being taken, so a stalled output stops the input after one byte.
// Reset: synchronous, active low; it returns the parser to the start of a file header.
`default_nettype none
`include "assert_macros.svh"

module bmp24_stream_decoder_top
  import bmp24_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // data_byte[7:0]
  input  wire logic        in_tlast,   // end_of_file
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // red[7:0], green[15:8], blue[23:16],
                                       // column[35:24], row[47:36], error_code[51:48]
  output logic             out_tuser,  // kind
  output logic             out_tlast   // last_pixel
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  typedef enum logic [2:0] {PH_HEADER, PH_SKIP, PH_PIXEL, PH_PAD, PH_DRAIN} phase_t;

  phase_t        phase_r, phase_nxt;
  logic [31:0]   pos_r, pos_nxt;
  logic [WW-1:0] col_r, col_nxt;
  logic [HW-1:0] row_r, row_nxt;
  logic [1:0]    bip_r, bip_nxt;
  logic [1:0]    pad_r, pad_nxt;
  logic [7:0]    blue_r, blue_nxt;
  logic [7:0]    green_r, green_nxt;

  logic          s1_vld_r;
  logic [7:0]    s1_byte_r;
  logic          s1_eof_r;

  logic          out_vld_r;
  logic          out_kind_r;
  logic [7:0]    out_red_r, out_green_r, out_blue_r;
  logic [11:0]   out_col_r, out_row_r;
  logic [3:0]    out_err_r;
  logic          out_last_r;

  logic          emit, e_kind, e_last;
  logic [3:0]    e_err;
  logic [11:0]   e_col, e_row;
  logic          restart;

  logic          res_free, go;
  logic          hdr_en;
  hdr_stat_t     hstat;
  logic [WW-1:0] width;
  logic [HW-1:0] height;
  logic [31:0]   pix_start;

  logic [WW-1:0] col_inc;
  logic [HW-1:0] row_inc;
  logic          col_end, row_end;
  logic [1:0]    pad_dec;
  logic [3:0]    hcode;

  assign res_free  = !out_vld_r || out_tready;
  assign go        = s1_vld_r && res_free;
  assign in_tready = !s1_vld_r || res_free;
  assign hdr_en    = go && (phase_r == PH_HEADER);

  bmp24_hdr #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_hdr (
    .clk       (clk),
    .rst_n     (rst_n),
    .hdr_en    (hdr_en),
    .hdr_clr   (go && restart),
    .pos       (pos_r[5:0]),
    .data_byte (s1_byte_r),
    .stat      (hstat),
    .width     (width),
    .height    (height),
    .pix_start (pix_start)
  );

  assign col_inc = col_r + WW'(1);
  assign row_inc = row_r + HW'(1);
  assign col_end = (col_inc == width);
  assign row_end = (row_inc == height);
  assign pad_dec = pad_r - 2'd1;

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    bip_nxt   = bip_r;
    pad_nxt   = pad_r;
    blue_nxt  = blue_r;
    green_nxt = green_r;
    emit      = 1'b0;
    e_kind    = 1'b1;
    e_err     = ERR_TRUNC;
    e_col     = '0;
    e_row     = '0;
    e_last    = 1'b0;
    restart   = s1_eof_r;
    hcode     = hstat.code;

    case (phase_r)
      PH_HEADER: begin
        pos_nxt = pos_r + 32'd1;
        if (pos_r[5:0] == HDR_LAST) begin
          if (hcode == ERR_NONE && s1_eof_r) begin
            hcode = ERR_TRUNC;
          end
          if (hcode != ERR_NONE) begin
            emit  = 1'b1;
            e_err = hcode;
            if (!s1_eof_r) begin
              phase_nxt = PH_DRAIN;
            end
          end else begin
            phase_nxt = hstat.start54 ? PH_PIXEL : PH_SKIP;
          end
        end else begin
          emit = s1_eof_r;
        end
      end
      PH_SKIP: begin
        pos_nxt = pos_r + 32'd1;
        if (pos_r == pix_start - 32'd1) begin
          phase_nxt = PH_PIXEL;
        end
        emit = s1_eof_r;
      end
      PH_PIXEL: begin
        case (bip_r)
          2'd0: begin
            blue_nxt = s1_byte_r;
            bip_nxt  = 2'd1;
            emit     = s1_eof_r;
          end
          2'd1: begin
            green_nxt = s1_byte_r;
            bip_nxt   = 2'd2;
            emit      = s1_eof_r;
          end
          default: begin
            bip_nxt = 2'd0;
            col_nxt = col_inc;
            if (col_end) begin
              col_nxt = '0;
              pad_nxt = 2'(width);
              if (2'(width) != 2'd0) begin
                phase_nxt = PH_PAD;
              end else begin
                row_nxt   = row_inc;
                phase_nxt = row_end ? PH_DRAIN : PH_PIXEL;
              end
            end
            emit = 1'b1;
            // Truncation replaces the pixel unless this was the image's final byte.
            if (!(s1_eof_r && phase_nxt == PH_DRAIN) && !(!s1_eof_r)) begin
              e_kind = 1'b1;
            end else begin
              e_kind = 1'b0;
              e_err  = ERR_NONE;
              e_col  = 12'(col_r);
              e_row  = hstat.top_down ? 12'(row_r) : 12'(height - HW'(1) - row_r);
              e_last = col_end && row_end;
            end
          end
        endcase
      end
      PH_PAD: begin
        pad_nxt = pad_dec;
        if (pad_dec == 2'd0) begin
          row_nxt   = row_inc;
          phase_nxt = row_end ? PH_DRAIN : PH_PIXEL;
        end
        emit = s1_eof_r && (phase_nxt != PH_DRAIN);
      end
      PH_DRAIN: begin
        emit = 1'b0;
      end
      default: begin
        phase_nxt = PH_HEADER;
      end
    endcase

    // The end-of-file byte always returns the parser to the start of a file.
    if (restart) begin
      phase_nxt = PH_HEADER;
      pos_nxt   = '0;
      col_nxt   = '0;
      row_nxt   = '0;
      bip_nxt   = '0;
      pad_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      pos_r    <= '0;
      col_r    <= '0;
      row_r    <= '0;
      bip_r    <= '0;
      pad_r    <= '0;
      s1_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_vld_r <= in_tvalid;
      end
      if (go) begin
        phase_r   <= phase_nxt;
        pos_r     <= pos_nxt;
        col_r     <= col_nxt;
        row_r     <= row_nxt;
        bip_r     <= bip_nxt;
        pad_r     <= pad_nxt;
        out_vld_r <= emit;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      s1_byte_r <= in_tdata;
      s1_eof_r  <= in_tlast;
    end
    if (go) begin
      blue_r  <= blue_nxt;
      green_r <= green_nxt;
      if (emit) begin
        out_kind_r  <= e_kind;
        out_red_r   <= e_kind ? 8'd0 : s1_byte_r;
        out_green_r <= e_kind ? 8'd0 : green_r;
        out_blue_r  <= e_kind ? 8'd0 : blue_r;
        out_col_r   <= e_col;
        out_row_r   <= e_row;
        out_err_r   <= e_err;
        out_last_r  <= e_last;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'd0, out_err_r, out_row_r, out_col_r,
                       out_blue_r, out_green_r, out_red_r};

  `ASSERT_IMPLY(a_err_no_last, out_vld_r && out_kind_r, !out_last_r,
                "error result marked as last pixel")
  `ASSERT_IMPLY(a_err_has_code, out_vld_r && out_kind_r, out_err_r != ERR_NONE,
                "error result without error code")
  `ASSERT_IMPLY(a_pix_no_code, out_vld_r && !out_kind_r, out_err_r == ERR_NONE,
                "pixel result with error code")
  `ASSERT_NEXT(a_eof_restart, go && s1_eof_r, phase_r == PH_HEADER && pos_r == 32'd0,
               "end of file did not restart the parser")
  `ASSERT_IMPLY(a_pad_nonzero, phase_r == PH_PAD, pad_r != 2'd0,
                "padding phase with no padding left")

endmodule

`default_nettype wire

// ===== src/bmp24_hdr.sv =====
`default_nettype none

module bmp24_hdr
  import bmp24_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          hdr_en,
  input  wire logic          hdr_clr,
  input  wire logic [5:0]    pos,
  input  wire logic [7:0]    data_byte,
  output hdr_stat_t          stat,
  output logic [WW-1:0]      width,
  output logic [HW-1:0]      height,
  output logic [31:0]        pix_start
);

  localparam logic [5:0] P_SIG    = 6'd1;
  localparam logic [5:0] P_OFFSET = 6'd13;
  localparam logic [5:0] P_INFO   = 6'd17;
  localparam logic [5:0] P_WIDTH  = 6'd21;
  localparam logic [5:0] P_HEIGHT = 6'd25;
  localparam logic [5:0] P_PLANES = 6'd27;
  localparam logic [5:0] P_DEPTH  = 6'd29;
  localparam logic [5:0] P_COMP   = 6'd33;
  localparam logic [5:0] P_CTAB   = 6'd49;

  localparam int NF = 10;
  localparam logic [3:0] FAULT_CODE [NF] = '{ERR_SIG, ERR_INFO, ERR_PLANES, ERR_DEPTH,
                                             ERR_COMP, ERR_DIMS, ERR_CTAB, ERR_OFFSET,
                                             ERR_DIMS, ERR_BIG};

  logic [31:0]   scratch_r;
  logic [31:0]   start_r;
  logic [WW-1:0] width_r;
  logic [HW-1:0] height_r;
  logic          top_down_r;
  logic          wneg_r;
  logic          wzero_r;
  logic          wbig_r;
  logic [NF-1:0] faults_r;
  logic [NF-1:0] faults_nxt;

  logic [31:0]   v;
  logic [15:0]   h16;
  logic [31:0]   absh;
  logic [NF-1:0] new_f;
  logic [3:0]    code;

  // The newest byte enters at the top, so v holds the last four bytes little-endian.
  assign v    = {data_byte, scratch_r[31:8]};
  assign h16  = v[31:16];
  assign absh = v[31] ? (~v + 32'd1) : v;

  always_comb begin
    new_f = '0;
    case (pos)
      P_SIG:    new_f[0] = (h16 != 16'h4D42);
      P_OFFSET: new_f[7] = (v < HDR_BYTES);
      P_INFO:   new_f[1] = (v != 32'd40);
      P_HEIGHT: begin
        new_f[5] = wneg_r | wzero_r | (v == 32'd0);
        new_f[8] = (v == 32'h8000_0000);
        new_f[9] = wbig_r | (absh > 32'(MAX_HEIGHT));
      end
      P_PLANES: new_f[2] = (h16 != 16'd1);
      P_DEPTH:  new_f[3] = (h16 != 16'd24);
      P_COMP:   new_f[4] = (v != 32'd0);
      P_CTAB:   new_f[6] = (v != 32'd0);
      default:  new_f = '0;
    endcase
  end

  always_comb begin
    faults_nxt = faults_r;
    if (hdr_clr) begin
      faults_nxt = '0;
    end else if (hdr_en) begin
      faults_nxt = faults_r | new_f;
    end
  end

  // Lowest set fault bit wins.
  always_comb begin
    code = ERR_NONE;
    for (int i = NF - 1; i >= 0; i--) begin
      if (faults_r[i]) begin
        code = FAULT_CODE[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      faults_r <= '0;
    end else begin
      faults_r <= faults_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_en) begin
      scratch_r <= v;
      case (pos)
        P_OFFSET: start_r <= v;
        P_WIDTH: begin
          width_r <= WW'(v);
          wneg_r  <= v[31];
          wzero_r <= (v == 32'd0);
          wbig_r  <= (v > 32'(MAX_WIDTH));
        end
        P_HEIGHT: begin
          height_r   <= HW'(absh);
          top_down_r <= v[31];
        end
        default: ;
      endcase
    end
  end

  assign stat.code     = code;
  assign stat.top_down = top_down_r;
  assign stat.start54  = (start_r == HDR_BYTES);
  assign width         = width_r;
  assign height        = height_r;
  assign pix_start     = start_r;

endmodule

`default_nettype wire
